FILE: hw/rtl/ip_route_hash_table_macros.svh
// Assertion macros for the route hash table, empty in synthesis.
`ifndef IP_ROUTE_HASH_TABLE_MACROS_SVH
`define IP_ROUTE_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check the consequent in the same cycle as the antecedent.
`define RHT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ip_route_hash_table: same-cycle check failed");

// Check the consequent in the cycle after the antecedent.
`define RHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ip_route_hash_table: next-cycle check failed");

`else

`define RHT_ASSERT_SAME(label, ante, cons)
`define RHT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/rht_pkg.sv
// Shared types and constants of the route hash table.
`timescale 1ns / 1ps

package rht_pkg;

    // Default geometry of the table
    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int PORT_W = 8;
    localparam int ST_W   = 3;

    // Hash weight of the lowest octet and width of the raw octet sum
    localparam int HASH_PRIME = 59;
    localparam int SUM_W      = $clog2(255 * (3 + HASH_PRIME) + 1);

    // Commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_HIT     = 3'd0;
    localparam logic [ST_W-1:0] ST_MISS    = 3'd1;
    localparam logic [ST_W-1:0] ST_NEW     = 3'd2;
    localparam logic [ST_W-1:0] ST_UPDATED = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    // One way of a bucket
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_entry;

    // Outcome of one bucket search
    typedef struct packed {
        logic              wr_en;
        logic [ST_W-1:0]   status;
        logic [PORT_W-1:0] port_out;
    } t_result;

endpackage

FILE: hw/rtl/rht_hash.sv
// Three-stage bucket index pipeline: octet sum, reciprocal multiply, remainder.
`timescale 1ns / 1ps

module rht_hash import rht_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ADDR_W-1:0]          i_ip_address,
    output logic                       o_valid,
    output logic [$clog2(BUCKETS)-1:0] o_index
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int PRD_W = 2 * SUM_W;
    localparam int RECIP = (1 << SUM_W) / BUCKETS;
    localparam logic [SUM_W-1:0] RECIP_C = SUM_W'(RECIP);
    localparam logic [SUM_W-1:0] BKT_C   = SUM_W'(BUCKETS);
    localparam logic [SUM_W-1:0] PRIME_C = SUM_W'(HASH_PRIME);

    logic [2:0]       r_valid;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_sum2;
    logic [SUM_W-1:0] r_quot;
    logic [BKT_W-1:0] r_index;

    logic [SUM_W-1:0] w_sum;
    logic [PRD_W-1:0] w_prod;
    logic [PRD_W-1:0] w_qb;
    logic [SUM_W-1:0] w_rem;
    logic [SUM_W-1:0] w_mod;

    // Weighted octet sum
    assign w_sum = SUM_W'(i_ip_address[31:24]) + SUM_W'(i_ip_address[23:16])
                 + SUM_W'(i_ip_address[15:8]) + SUM_W'(i_ip_address[7:0]) * PRIME_C;

    // Quotient estimate, at most one below the true quotient
    assign w_prod = PRD_W'(r_sum) * PRD_W'(RECIP_C);

    // Remainder with a single correction step
    assign w_qb  = PRD_W'(r_quot) * PRD_W'(BKT_C);
    assign w_rem = r_sum2 - w_qb[SUM_W-1:0];
    assign w_mod = (w_rem >= BKT_C) ? (w_rem - BKT_C) : w_rem;

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Advance the data stages
    always_ff @(posedge i_clk) begin
        r_sum   <= w_sum;
        r_sum2  <= r_sum;
        r_quot  <= w_prod[PRD_W-1:SUM_W];
        r_index <= w_mod[BKT_W-1:0];
    end

    assign o_valid = r_valid[2];
    assign o_index = r_index;

endmodule

FILE: hw/rtl/rht_mem.sv
// Bucket memory: one row of all ways per bucket, one write and one read port.
`timescale 1ns / 1ps

module rht_mem import rht_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(BUCKETS)-1:0] i_wr_addr,
    input  t_entry [WAYS-1:0]          i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(BUCKETS)-1:0] i_rd_addr,
    output t_entry [WAYS-1:0]          o_rd_data
);

    t_entry [WAYS-1:0] r_mem [BUCKETS];
    t_entry [WAYS-1:0] r_rd_data;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one row, hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/rht_match.sv
// Bucket search and row update: exact match, first free way, status.
`timescale 1ns / 1ps

module rht_match import rht_pkg::*; #(
    parameter int WAYS = WAYS_DEF
) (
    input  t_entry [WAYS-1:0] i_row,
    input  logic              i_cmd,
    input  logic [ADDR_W-1:0] i_ip_address,
    input  logic [PORT_W-1:0] i_port_value,
    output t_entry [WAYS-1:0] o_row,
    output t_result           o_result
);

    logic [WAYS-1:0]   w_hit;
    logic [WAYS-1:0]   w_free;
    logic [WAYS-1:0]   w_first;
    logic [PORT_W-1:0] w_hit_port;

    // Compare every way and gather the port of the matching one
    always_comb begin
        w_hit_port = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_hit[w]  = i_row[w].valid && (i_row[w].addr == i_ip_address);
            w_free[w] = !i_row[w].valid;
            if (w_hit[w]) begin
                w_hit_port = w_hit_port | i_row[w].port;
            end
        end
    end

    // Lowest free way
    assign w_first = w_free & (~w_free + WAYS'(1));

    // Build the written-back row and the result
    always_comb begin
        o_row             = i_row;
        o_result.wr_en    = 1'b0;
        o_result.status   = ST_FULL;
        o_result.port_out = '0;
        if (i_cmd == CMD_LOOKUP) begin
            if (|w_hit) begin
                o_result.status   = ST_HIT;
                o_result.port_out = w_hit_port;
            end else begin
                o_result.status = ST_MISS;
            end
        end else if (|w_hit) begin
            o_result.wr_en  = 1'b1;
            o_result.status = ST_UPDATED;
            for (int w = 0; w < WAYS; w++) begin
                if (w_hit[w]) begin
                    o_row[w].port = i_port_value;
                end
            end
        end else if (|w_free) begin
            o_result.wr_en  = 1'b1;
            o_result.status = ST_NEW;
            for (int w = 0; w < WAYS; w++) begin
                if (w_first[w]) begin
                    o_row[w].valid = 1'b1;
                    o_row[w].addr  = i_ip_address;
                    o_row[w].port  = i_port_value;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/ip_route_hash_table.sv
// Top level of the IPv4 route hash table: control sequencer and output register.
`timescale 1ns / 1ps
`include "ip_route_hash_table_macros.svh"

// Route table keyed by a 32-bit IPv4 address, BUCKETS buckets of WAYS ways.
// Input channel: i_valid / o_stall with i_cmd, i_ip_address, i_port_value.
//   An insert updates the port of a present address or fills the lowest free
//   way of its bucket; a lookup returns the stored port.
// Output channel: o_valid / i_stall with o_status and o_port_out, one result
//   per item, in order.
// Path: an accepted item passes the 3 hash stages and 1 memory read; then
//   the result is registered and the row written back in the same cycle.
// Item order: the whole bucket row lives in one memory that is read once and
//   written at most once per item, and the next item enters only after the
//   previous one commits, so no two accesses to a row overlap.
// Reset: a clearing pass writes an empty row to every bucket, one per cycle;
//   o_stall stays high meanwhile.
// Receiver stall: the result waits in the output register; the next item is
//   accepted and processed, and its write-back and result hold in the last
//   step until the output register frees up.
module ip_route_hash_table import rht_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  logic [ADDR_W-1:0] i_ip_address,
    input  logic [PORT_W-1:0] i_port_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [PORT_W-1:0] o_port_out
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MODIFY
    } t_state;

    t_state            r_state;
    logic [BKT_W-1:0]  r_clr_idx;
    logic [BKT_W-1:0]  r_idx;
    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [PORT_W-1:0] r_port;
    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [PORT_W-1:0] r_port_out;

    logic              w_accept;
    logic              w_commit;
    logic              w_clearing;
    logic              w_hash_valid;
    logic [BKT_W-1:0]  w_hash_index;
    logic              w_wr_en;
    logic [BKT_W-1:0]  w_wr_addr;
    t_entry [WAYS-1:0] w_wr_data;
    t_entry [WAYS-1:0] w_rd_row;
    t_entry [WAYS-1:0] w_new_row;
    t_result           w_result;

    // Handshake and commit conditions
    assign w_clearing = (r_state == S_CLEAR);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_commit   = (r_state == S_MODIFY) && (!r_out_valid || !i_stall);

    // Bucket index
    rht_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept),
        .i_ip_address (i_ip_address),
        .o_valid      (w_hash_valid),
        .o_index      (w_hash_index)
    );

    // Write port: clearing pass or write-back of the modified row
    assign w_wr_en   = w_clearing || (w_commit && w_result.wr_en);
    assign w_wr_addr = w_clearing ? r_clr_idx : r_idx;
    assign w_wr_data = w_clearing ? '0 : w_new_row;

    rht_mem #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_hash_valid),
        .i_rd_addr (w_hash_index),
        .o_rd_data (w_rd_row)
    );

    // Search the bucket and build its new contents
    rht_match #(
        .WAYS (WAYS)
    ) u_match (
        .i_row        (w_rd_row),
        .i_cmd        (r_cmd),
        .i_ip_address (r_addr),
        .i_port_value (r_port),
        .o_row        (w_new_row),
        .o_result     (w_result)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + BKT_W'(1);
                    if (r_clr_idx == LAST_BKT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_cmd;
                        r_addr  <= i_ip_address;
                        r_port  <= i_port_value;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_valid) begin
                        r_idx   <= w_hash_index;
                        r_state <= S_MODIFY;
                    end
                end
                S_MODIFY: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase

            // Load a new result, or drop the one just taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_status    <= w_result.status;
                r_port_out  <= w_result.port_out;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_port_out = r_port_out;

    // Checks
    `RHT_ASSERT_SAME(a_no_result_while_clearing, w_clearing, !r_out_valid)
    `RHT_ASSERT_NEXT(a_accept_starts_hash, w_accept, r_state == S_HASH)
    `RHT_ASSERT_NEXT(a_lookup_status, w_commit && (r_cmd == CMD_LOOKUP), (r_status == ST_HIT) || (r_status == ST_MISS))
    `RHT_ASSERT_SAME(a_port_only_on_hit, r_out_valid && (r_status != ST_HIT), r_port_out == '0)

endmodule

FILE: tb/ip_route_hash_table_tb.sv
// Self-checking testbench of the IPv4 route hash table with its own table predictor.
`timescale 1ns / 1ps

module ip_route_hash_table_tb import rht_pkg::*; ();

    localparam int ENTRIES = BUCKETS_DEF * WAYS_DEF;

    // Status and port that one item is predicted to return
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PORT_W-1:0] port_out;
    } t_route_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_cmd;
    logic [ADDR_W-1:0] i_ip_address;
    logic [PORT_W-1:0] i_port_value;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [ST_W-1:0]   o_status;
    logic [PORT_W-1:0] o_port_out;

    // Shadow copy of the routing table
    bit                route_valid [ENTRIES];
    bit [ADDR_W-1:0]   route_addr  [ENTRIES];
    bit [PORT_W-1:0]   route_port  [ENTRIES];

    t_route_result     expected_routes [$];
    logic [ADDR_W-1:0] known_addrs [$];
    t_route_result     route_want;
    int                error_count   = 0;
    int                send_idle_pct = 0;
    int                stall_pct     = 0;

    ip_route_hash_table u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_ip_address (i_ip_address),
        .i_port_value (i_port_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_port_out   (o_port_out)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Weighted octet sum of an address, folded into a bucket number
    function automatic int route_bucket(logic [ADDR_W-1:0] addr);
        return (int'(addr[31:24]) + int'(addr[23:16]) + int'(addr[15:8])
                + int'(addr[7:0]) * HASH_PRIME) % BUCKETS_DEF;
    endfunction

    // Build an address that lands in bucket b, with the given second octet
    function automatic logic [ADDR_W-1:0] addr_in_bucket(int b, logic [7:0] o2);
        logic [7:0] o3;
        logic [7:0] o4;
        int         o1;
        o3 = 8'($urandom_range(255));
        o4 = 8'($urandom_range(255));
        o1 = ((b - int'(o2) - int'(o3) - int'(o4) * HASH_PRIME) % 256 + 256) % 256;
        return {o1[7:0], o2, o3, o4};
    endfunction

    // Apply one item to the shadow table and return its result
    function automatic t_route_result predict_route(logic cmd, logic [ADDR_W-1:0] addr,
                                                    logic [PORT_W-1:0] port);
        t_route_result res;
        int            base;
        int            hit_way;
        base         = route_bucket(addr) * WAYS_DEF;
        hit_way      = -1;
        res.status   = ST_MISS;
        res.port_out = '0;
        for (int w = 0; w < WAYS_DEF; w++) begin
            if (hit_way < 0 && route_valid[base + w] && route_addr[base + w] == addr) begin
                hit_way = w;
            end
        end
        if (cmd == CMD_LOOKUP) begin
            if (hit_way >= 0) begin
                res.status   = ST_HIT;
                res.port_out = route_port[base + hit_way];
            end
        end else if (hit_way >= 0) begin
            route_port[base + hit_way] = port;
            res.status = ST_UPDATED;
        end else begin
            // Fill the lowest free way, or report the bucket full
            res.status = ST_FULL;
            for (int w = 0; w < WAYS_DEF; w++) begin
                if (res.status == ST_FULL && !route_valid[base + w]) begin
                    route_valid[base + w] = 1'b1;
                    route_addr[base + w]  = addr;
                    route_port[base + w]  = port;
                    res.status = ST_NEW;
                end
            end
        end
        return res;
    endfunction

    // Send one item: optional idle gap, then hold until accepted. Enter and leave at negedge.
    task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [PORT_W-1:0] port);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_cmd        = cmd;
        i_ip_address = addr;
        i_port_value = port;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        expected_routes.push_back(predict_route(cmd, addr, port));
        if (cmd == CMD_INSERT) begin
            known_addrs.push_back(addr);
        end
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        i_valid = 1'b0;
        while (expected_routes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Look up the extreme addresses in an empty table
    task automatic test_empty_lookup();
        send_item(CMD_LOOKUP, 32'h0000_0000, 8'hFF);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        drain_results();
    endtask

    // Insert, update and read back the extreme addresses and ports
    task automatic test_insert_update();
        send_item(CMD_INSERT, 32'h0000_0000, 8'hFF);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'h00);
        send_item(CMD_LOOKUP, 32'h0000_0000, 8'h5A);
        send_item(CMD_INSERT, 32'h0000_0000, 8'h00);
        send_item(CMD_LOOKUP, 32'h0000_0000, 8'hFF);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 8'hA5);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);
        drain_results();
    endtask

    // Overfill one bucket, then check miss, update and hit around the full bucket
    task automatic test_bucket_full();
        logic [ADDR_W-1:0] addrs [WAYS_DEF + 1];
        foreach (addrs[i]) begin
            addrs[i] = addr_in_bucket(77, 8'(i * 3 + 1));
        end
        foreach (addrs[i]) begin
            send_item(CMD_INSERT, addrs[i], 8'($urandom_range(255)));
        end
        send_item(CMD_LOOKUP, addrs[WAYS_DEF], 8'h00);
        send_item(CMD_INSERT, addrs[WAYS_DEF - 2], 8'hC3);
        send_item(CMD_LOOKUP, addrs[WAYS_DEF - 2], 8'h00);
        send_item(CMD_INSERT, addrs[WAYS_DEF - 1], 8'h3C);
        drain_results();
    endtask

    // Mixed traffic: known addresses, hot buckets, near misses and fresh addresses
    task automatic test_random_traffic(input int n_items, input int idle, input int stall);
        logic [ADDR_W-1:0] addr;
        logic              cmd;
        int                pick;
        int                hot [8];
        send_idle_pct = idle;
        stall_pct     = stall;
        foreach (hot[i]) begin
            hot[i] = $urandom_range(BUCKETS_DEF - 1);
        end
        repeat (n_items) begin
            pick = $urandom_range(99);
            cmd  = 1'($urandom_range(1));
            addr = $urandom();
            if (known_addrs.size() == 0 || pick >= 80) begin
                // keep the fresh random address
            end else if (pick < 35) begin
                addr = known_addrs[$urandom_range(known_addrs.size() - 1)];
            end else if (pick < 60) begin
                addr = addr_in_bucket(hot[$urandom_range(7)], 8'($urandom_range(255)));
                cmd  = ($urandom_range(99) < 80) ? CMD_INSERT : CMD_LOOKUP;
            end else if (pick < 70) begin
                // Same bucket, different address: shift one count between top octets
                addr = known_addrs[$urandom_range(known_addrs.size() - 1)];
                addr = {addr[31:24] + 8'd1, addr[23:16] - 8'd1, addr[15:0]};
            end else begin
                addr = known_addrs[$urandom_range(known_addrs.size() - 1)];
                addr[$urandom_range(ADDR_W - 1)] ^= 1'b1;
            end
            send_item(cmd, addr, 8'($urandom_range(255)));
        end
        drain_results();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // Receiver stall at the configured rate
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_routes.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: status %0d port 0x%02h", o_status, o_port_out);
                end
            end else begin
                route_want = expected_routes.pop_front();
                if (o_status !== route_want.status || o_port_out !== route_want.port_out) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: expected status %0d port 0x%02h, %s %0d port 0x%02h",
                                 route_want.status, route_want.port_out, "got status",
                                 o_status, o_port_out);
                    end
                end
            end
        end
    end

    // Reset, directed tests, random phases, then the verdict
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = CMD_INSERT;
        i_ip_address = '0;
        i_port_value = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_lookup();
        test_insert_update();
        test_bucket_full();
        test_random_traffic(475, 0, 0);
        test_random_traffic(475, 63, 0);
        test_random_traffic(475, 0, 63);
        test_random_traffic(475, 11, 11);

        drain_results();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && expected_routes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
